FILE: design/simplified_aes_cipher_assert.svh
// assertion macros for the simplified aes cipher
// needs clk and rst_n in the scope of each use
`ifndef SIMPLIFIED_AES_CIPHER_ASSERT_SVH
`define SIMPLIFIED_AES_CIPHER_ASSERT_SVH

// same-cycle implication
`define SAES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/saes_pkg.sv
// types, constants and cipher functions for the simplified aes cipher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package saes_pkg;

  localparam int unsigned BLK_W = 16;
  localparam int unsigned NIB_W = 4;
  localparam int unsigned HALF_W = 8;

  typedef logic [BLK_W-1:0] blk_t;
  typedef logic [NIB_W-1:0] nib_t;
  typedef logic [HALF_W-1:0] half_t;

  typedef enum logic {
    CMD_ENC = 1'b0,
    CMD_DEC = 1'b1
  } cmd_t;

  typedef struct packed {
    blk_t k0;
    blk_t k1;
    blk_t k2;
  } rkeys_t;

  localparam logic [NIB_W:0] GF_POLY = 5'h13;
  localparam half_t RCON1 = 8'h80;
  localparam half_t RCON2 = 8'h30;
  localparam nib_t MIX_ENC0 = 4'h1;
  localparam nib_t MIX_ENC1 = 4'h4;
  localparam nib_t MIX_DEC0 = 4'h9;
  localparam nib_t MIX_DEC1 = 4'h2;
  localparam blk_t KEY_RST = 16'h0000;

  localparam nib_t SBOX_FWD [16] = '{
    4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
    4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
  };

  localparam nib_t SBOX_INV [16] = '{
    4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
    4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
  };

  function automatic nib_t gf_mul(input nib_t a, input nib_t b);
    nib_t acc;
    logic [NIB_W:0] t;
    acc = '0;
    t = {1'b0, a};
    for (int i = 0; i < NIB_W; i++) begin
      if (b[i]) begin
        acc = acc ^ t[NIB_W-1:0];
      end
      t = {t[NIB_W-1:0], 1'b0};
      if (t[NIB_W]) begin
        t = t ^ GF_POLY;
      end
    end
    return acc;
  endfunction

  function automatic blk_t sub_nib(input blk_t s, input logic inv);
    blk_t r;
    for (int i = 0; i < 4; i++) begin
      r[i*NIB_W +: NIB_W] = inv ? SBOX_INV[s[i*NIB_W +: NIB_W]]
                                : SBOX_FWD[s[i*NIB_W +: NIB_W]];
    end
    return r;
  endfunction

  // swaps nibble 1 and nibble 3, self-inverse
  function automatic blk_t shift_rows(input blk_t s);
    return {s[15:12], s[3:0], s[7:4], s[11:8]};
  endfunction

  function automatic blk_t mix_cols(input blk_t s, input nib_t m0, input nib_t m1);
    nib_t n0, n1, n2, n3;
    n0 = s[15:12];
    n1 = s[11:8];
    n2 = s[7:4];
    n3 = s[3:0];
    return {gf_mul(m0, n0) ^ gf_mul(m1, n1),
            gf_mul(m1, n0) ^ gf_mul(m0, n1),
            gf_mul(m0, n2) ^ gf_mul(m1, n3),
            gf_mul(m1, n2) ^ gf_mul(m0, n3)};
  endfunction

  function automatic blk_t next_key(input blk_t k, input half_t rc);
    half_t w0, w1, g, w2, w3;
    w0 = k[15:8];
    w1 = k[7:0];
    g = {SBOX_FWD[w1[3:0]], SBOX_FWD[w1[7:4]]} ^ rc;
    w2 = w0 ^ g;
    w3 = w2 ^ w1;
    return {w2, w3};
  endfunction

  function automatic rkeys_t expand_key(input blk_t k);
    rkeys_t rk;
    rk.k0 = k;
    rk.k1 = next_key(k, RCON1);
    rk.k2 = next_key(rk.k1, RCON2);
    return rk;
  endfunction

endpackage

`default_nettype wire

FILE: design/saes_ifs.sv
// valid/ready channel interfaces for the simplified aes cipher
// depends on saes_pkg
`timescale 1ns / 1ps
`default_nettype none

interface saes_in_if
  import saes_pkg::*;
();
  logic valid;
  logic ready;
  logic cmd;
  blk_t data_in;

  modport source (output valid, output cmd, output data_in, input ready);
  modport sink (input valid, input cmd, input data_in, output ready);
endinterface

interface saes_out_if
  import saes_pkg::*;
();
  logic valid;
  logic ready;
  blk_t data_out;

  modport source (output valid, output data_out, input ready);
  modport sink (input valid, input data_out, output ready);
endinterface

interface saes_cfg_if
  import saes_pkg::*;
();
  logic valid;
  logic ready;
  blk_t cipher_key;

  modport source (output valid, output cipher_key, input ready);
  modport sink (input valid, input cipher_key, output ready);
endinterface

`default_nettype wire

FILE: design/saes_key_exp.sv
// key register and round key expansion, updated on each key write
// depends on saes_pkg, saes_ifs and simplified_aes_cipher_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "simplified_aes_cipher_assert.svh"

module saes_key_exp
  import saes_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  saes_cfg_if.sink    cfg,
  output rkeys_t      rkeys
);

  rkeys_t rk_r;
  rkeys_t rk_nxt;
  logic   wr;

  assign cfg.ready = 1'b1;
  assign wr = cfg.valid & cfg.ready;

  always_comb begin
    rk_nxt = rk_r;
    if (wr) begin
      rk_nxt = expand_key(cfg.cipher_key);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rk_r <= expand_key(KEY_RST);
    end else begin
      rk_r <= rk_nxt;
    end
  end

  assign rkeys = rk_r;

  `SAES_ASSERT_NEXT(a_key_loaded, wr, rk_r.k0 == $past(cfg.cipher_key), "key word not stored")
  `SAES_ASSERT_NOW(a_key_chain, 1'b1, rk_r.k2 == next_key(rk_r.k1, RCON2), "round keys out of step")
  `SAES_ASSERT_NEXT(a_key_hold, !wr, $stable(rk_r), "round keys changed without a write")

endmodule

`default_nettype wire

FILE: design/saes_core.sv
// one-pass encrypt/decrypt datapath for a 16-bit block
// depends on saes_pkg
`timescale 1ns / 1ps
`default_nettype none

module saes_core
  import saes_pkg::*;
(
  input  wire logic   cmd,
  input  wire blk_t   blk,
  input  wire rkeys_t rkeys,
  output blk_t        res
);

  blk_t enc_a, enc_b, enc_c;
  blk_t dec_a, dec_b, dec_c;

  always_comb begin
    enc_a = shift_rows(sub_nib(blk ^ rkeys.k0, 1'b0));
    enc_b = mix_cols(enc_a, MIX_ENC0, MIX_ENC1) ^ rkeys.k1;
    enc_c = shift_rows(sub_nib(enc_b, 1'b0)) ^ rkeys.k2;

    dec_a = sub_nib(shift_rows(blk ^ rkeys.k2), 1'b1) ^ rkeys.k1;
    dec_b = mix_cols(dec_a, MIX_DEC0, MIX_DEC1);
    dec_c = sub_nib(shift_rows(dec_b), 1'b1) ^ rkeys.k0;

    case (cmd_t'(cmd))
      CMD_ENC: res = enc_c;
      CMD_DEC: res = dec_c;
      default: res = enc_c;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/simplified_aes_cipher.sv
// simplified aes cipher top level: input register, cipher datapath, result register
// depends on saes_pkg, saes_ifs, saes_key_exp, saes_core and simplified_aes_cipher_assert.svh
//
// Takes one word per cycle unless a stalled result holds up the input register. The
// accepted block sits in an input register and one combinational pass through both
// rounds fills the result register, which holds the result word until it is taken.
// A stalled result holds while one more word waits in the input register. The round
// keys are expanded and registered when the key is written; cfg_if is always ready
// and a new key applies to every word that is still in the input register, so write
// it only while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "simplified_aes_cipher_assert.svh"

module simplified_aes_cipher
  import saes_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  saes_in_if.sink     in_if,
  saes_out_if.source  out_if,
  saes_cfg_if.sink    cfg_if
);

  rkeys_t rkeys;

  logic s1_v_r, s1_v_nxt;
  logic s1_cmd_r;
  blk_t s1_blk_r;
  logic out_v_r, out_v_nxt;
  blk_t out_d_r;
  blk_t res;
  logic out_load;
  logic in_acc;

  saes_key_exp u_key_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_if),
    .rkeys (rkeys)
  );

  saes_core u_core (
    .cmd   (s1_cmd_r),
    .blk   (s1_blk_r),
    .rkeys (rkeys),
    .res   (res)
  );

  assign out_load = !out_v_r || out_if.ready;
  assign in_if.ready = !s1_v_r || out_load;
  assign in_acc = in_if.valid && in_if.ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (out_load) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (out_load) begin
      out_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r <= in_if.cmd;
      s1_blk_r <= in_if.data_in;
    end
    if (out_load && s1_v_r) begin
      out_d_r <= res;
    end
  end

  assign out_if.valid = out_v_r;
  assign out_if.data_out = out_d_r;

  `SAES_ASSERT_NEXT(a_s1_moves, s1_v_r && out_load, out_v_r, "input word lost on its way out")
  `SAES_ASSERT_NEXT(a_s1_holds, s1_v_r && !out_load, s1_v_r && $stable(s1_blk_r), "held word changed")
  `SAES_ASSERT_NOW(a_no_overrun, in_acc && s1_v_r, out_load, "input register overwritten")
  `SAES_ASSERT_NEXT(a_result_value, s1_v_r && out_load, out_d_r == $past(res), "result not captured")

endmodule

`default_nettype wire
